/* src/tld_pkg.sv */
// ----------------------------------------------------------------------------
// tld_pkg
// Types, character codes and small helpers shared by the line discipline.
// ----------------------------------------------------------------------------
package tld_pkg;

    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CTRL_OFFSET = 8'h40;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_FLAGS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_FLAGS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CHAR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EOF_CHAR    = 3'd3;

    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_BLOCK = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0] input_flags;
        logic [4:0] local_flags;
        logic [7:0] erase_char;
        logic [7:0] eof_char;
    } cfg_t;

    typedef enum logic [2:0] {
        PAT_CHAR,
        PAT_CARET,
        PAT_RUBOUT,
        PAT_RUBOUT2,
        PAT_BLOCK,
        PAT_ZERO
    } pat_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ECHO,
        B_ERASE,
        B_READ
    } back_state_t;

    typedef struct packed {
        logic       is_read;
        logic       canon;
        logic [7:0] c;
        logic       erase;
        logic       store;
        logic       raise;
        logic       echo_any;
        pat_t       pat;
        logic       erase_echo;
        logic       erase_ctl;
        logic [6:0] count;
    } cmd_t;

    function automatic logic is_control(logic [7:0] b);
        return (b < CH_SP) || (b == CH_DEL);
    endfunction

    function automatic logic [2:0] pat_len(pat_t pat);
        logic [2:0] n;
        case (pat)
            PAT_CARET:   n = 3'd2;
            PAT_RUBOUT:  n = 3'd3;
            PAT_RUBOUT2: n = 3'd6;
            default:     n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] pat_kind(pat_t pat);
        logic [1:0] k;
        case (pat)
            PAT_BLOCK: k = KIND_BLOCK;
            PAT_ZERO:  k = KIND_EMPTY;
            default:   k = KIND_ECHO;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] pat_value(pat_t pat, logic [2:0] idx, logic [7:0] b);
        logic [7:0] v;
        case (pat)
            PAT_CHAR:    v = b;
            PAT_CARET:   v = (idx == 3'd0) ? CH_CARET : b + CTRL_OFFSET;
            PAT_RUBOUT,
            PAT_RUBOUT2: v = (idx == 3'd1 || idx == 3'd4) ? CH_SP : CH_BS;
            default:     v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

/* src/tld_front.sv */
// ----------------------------------------------------------------------------
// tld_front
// Accepts transactions, translates received bytes and classifies them into
// commands for the back end.
// ----------------------------------------------------------------------------
module tld_front #(
    parameter int READ_MAX = 64
) (
    input  tld_pkg::cfg_t cfg,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_operation,
    input  logic [7:0]    s_rx_byte,
    input  logic [6:0]    s_read_count,
    output logic          push_valid,
    output tld_pkg::cmd_t push_cmd,
    input  logic          push_ready
);
    import tld_pkg::*;

    localparam logic [6:0] READ_LIMIT = 7'(READ_MAX);

    logic       drop;
    logic [7:0] c;
    logic       canon;
    logic       erase;
    logic       echo_on;
    logic       skip;
    logic       caret;

    always_comb begin
        c    = s_rx_byte;
        drop = 1'b0;
        if (s_rx_byte == CH_CR) begin
            if (cfg.input_flags[0]) begin
                drop = 1'b1;
            end else if (cfg.input_flags[1]) begin
                c = CH_LF;
            end
        end else if (s_rx_byte == CH_LF) begin
            if (cfg.input_flags[2]) begin
                c = CH_CR;
            end
        end

        canon   = cfg.local_flags[0];
        erase   = canon && cfg.local_flags[2] && (c == cfg.erase_char);
        echo_on = canon && !erase
                  && (cfg.local_flags[1] || (cfg.local_flags[3] && c == CH_LF));
        skip    = echo_on && (c == cfg.eof_char);
        caret   = echo_on && !skip && (c != CH_LF) && is_control(c) && cfg.local_flags[4];

        push_cmd.is_read    = s_operation;
        push_cmd.canon      = canon;
        push_cmd.c          = c;
        push_cmd.erase      = erase;
        push_cmd.store      = !erase && !skip;
        push_cmd.raise      = (c == CH_LF) || (c == cfg.eof_char) || !canon;
        push_cmd.echo_any   = echo_on && !skip;
        push_cmd.pat        = caret ? PAT_CARET : PAT_CHAR;
        push_cmd.erase_echo = cfg.local_flags[1];
        push_cmd.erase_ctl  = cfg.local_flags[4];
        push_cmd.count      = (s_read_count > READ_LIMIT) ? READ_LIMIT : s_read_count;
    end

    assign s_ready    = push_ready;
    assign push_valid = s_valid && (s_operation || !drop);

endmodule

/* src/tld_cmd_queue.sv */
// ----------------------------------------------------------------------------
// tld_cmd_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tld_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    input  tld_pkg::cmd_t push_cmd,
    output logic          push_ready,
    input  logic          pop,
    output logic          pop_valid,
    output tld_pkg::cmd_t pop_cmd
);
    import tld_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [NW-1:0] FULL_COUNT = NW'(QUEUE_DEPTH);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/tld_back.sv */
// ----------------------------------------------------------------------------
// tld_back
// Executes commands: holds the byte FIFO and its counters, produces echo and
// read results into the output register.
// ----------------------------------------------------------------------------
module tld_back #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    input  tld_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_kind,
    output logic [7:0]    m_value,
    output logic          m_last,
    output logic          m_readable,
    output logic          m_overflowed
);
    import tld_pkg::*;

    localparam int AW   = $clog2(FIFO_DEPTH);
    localparam int CW   = $clog2(FIFO_DEPTH + 1);
    localparam int CMPW = (AW + 1 > 7) ? AW + 1 : 7;
    localparam logic [AW-1:0] LAST_IDX  = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_FILL = CW'(FIFO_DEPTH);
    localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(FIFO_DEPTH);

    function automatic logic [AW-1:0] inc_idx(logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] dec_idx(logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    logic [7:0]    mem [FIFO_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    back_state_t   state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] nl_total_reg, nl_total_next;
    logic [AW-1:0] last_lf_reg, last_lf_next;
    logic          readable_reg, readable_next;
    logic          ovf_reg, ovf_next;
    pat_t          pat_reg, pat_next;
    logic [2:0]    idx_reg, idx_next;
    logic [7:0]    byte_reg, byte_next;
    logic [6:0]    remain_reg, remain_next;
    logic          canon_reg, canon_next;
    logic          erase_echo_reg, erase_echo_next;
    logic          erase_ctl_reg, erase_ctl_next;

    logic          m_valid_reg;
    logic [1:0]    m_kind_reg;
    logic [7:0]    m_value_reg;
    logic          m_last_reg;
    logic          m_readable_reg;
    logic          m_ovf_reg;

    logic          out_free;
    logic          emit;
    logic [1:0]    emit_kind;
    logic [7:0]    emit_value;
    logic          emit_last;

    logic [AW-1:0] tail;
    logic [6:0]    take;
    logic [AW:0]   lf_gap;
    logic          lf_taken;
    logic          read_ra;
    logic          echo_done;
    logic          read_done;
    logic          erase_keep;

    assign out_free = !m_valid_reg || m_ready;
    assign tail     = dec_idx(wr_ptr_reg);
    assign take     = (CMPW'(cmd.count) > CMPW'(fill_reg)) ? 7'(fill_reg) : cmd.count;
    assign lf_gap   = {1'b0, last_lf_reg} - {1'b0, head_reg}
                      + ((last_lf_reg < head_reg) ? DEPTH_W : '0);
    assign lf_taken = CMPW'(lf_gap) < CMPW'(take);

    always_comb begin
        if (cmd.canon) begin
            if (nl_total_reg == '0) begin
                read_ra = 1'b0;
            end else if (nl_total_reg == CW'(1)) begin
                read_ra = !lf_taken;
            end else begin
                read_ra = 1'b1;
            end
        end else begin
            read_ra = (CMPW'(fill_reg) != CMPW'(take));
        end
    end

    assign echo_done  = (idx_reg == pat_len(pat_reg) - 3'd1);
    assign read_done  = (remain_reg == 7'd1) || (canon_reg && rd_data_reg == CH_LF);
    assign erase_keep = (rd_data_reg == CH_LF);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.is_read) begin
                        if (!readable_reg || take == '0) begin
                            state_next = B_ECHO;
                        end else begin
                            state_next = B_READ;
                        end
                    end else if (cmd.erase) begin
                        state_next = (fill_reg != '0) ? B_ERASE : B_IDLE;
                    end else begin
                        state_next = cmd.echo_any ? B_ECHO : B_IDLE;
                    end
                end
            end
            B_ECHO: begin
                if (out_free && echo_done) begin
                    state_next = B_IDLE;
                end
            end
            B_ERASE: begin
                state_next = (!erase_keep && erase_echo_reg) ? B_ECHO : B_IDLE;
            end
            B_READ: begin
                if (out_free && read_done) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        rd_addr         = head_reg;
        emit            = 1'b0;
        emit_kind       = KIND_ECHO;
        emit_value      = 8'h00;
        emit_last       = 1'b0;
        head_next       = head_reg;
        wr_ptr_next     = wr_ptr_reg;
        fill_next       = fill_reg;
        nl_total_next   = nl_total_reg;
        last_lf_next    = last_lf_reg;
        readable_next   = readable_reg;
        ovf_next        = ovf_reg;
        pat_next        = pat_reg;
        idx_next        = idx_reg;
        byte_next       = byte_reg;
        remain_next     = remain_reg;
        canon_next      = canon_reg;
        erase_echo_next = erase_echo_reg;
        erase_ctl_next  = erase_ctl_reg;
        case (state_reg)
            B_IDLE: begin
                idx_next = 3'd0;
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    if (cmd.is_read) begin
                        canon_next  = cmd.canon;
                        remain_next = take;
                        if (!readable_reg) begin
                            pat_next = PAT_BLOCK;
                        end else begin
                            readable_next = read_ra;
                            pat_next      = PAT_ZERO;
                        end
                    end else if (cmd.erase) begin
                        rd_addr         = tail;
                        erase_echo_next = cmd.erase_echo;
                        erase_ctl_next  = cmd.erase_ctl;
                    end else begin
                        if (cmd.store) begin
                            if (fill_reg == FULL_FILL) begin
                                ovf_next = 1'b1;
                            end else begin
                                mem_we      = 1'b1;
                                wr_ptr_next = inc_idx(wr_ptr_reg);
                                fill_next   = fill_reg + 1'b1;
                                if (cmd.c == CH_LF) begin
                                    nl_total_next = nl_total_reg + 1'b1;
                                    last_lf_next  = wr_ptr_reg;
                                end
                            end
                        end
                        if (cmd.raise) begin
                            readable_next = 1'b1;
                        end
                        pat_next  = cmd.pat;
                        byte_next = cmd.c;
                    end
                end
            end
            B_ECHO: begin
                emit_kind  = pat_kind(pat_reg);
                emit_value = pat_value(pat_reg, idx_reg, byte_reg);
                emit_last  = echo_done;
                if (out_free) begin
                    emit     = 1'b1;
                    idx_next = idx_reg + 3'd1;
                end
            end
            B_ERASE: begin
                idx_next = 3'd0;
                if (!erase_keep) begin
                    fill_next   = fill_reg - 1'b1;
                    wr_ptr_next = tail;
                    pat_next    = (erase_ctl_reg && is_control(rd_data_reg))
                                  ? PAT_RUBOUT2 : PAT_RUBOUT;
                end
            end
            B_READ: begin
                emit_kind  = KIND_DATA;
                emit_value = rd_data_reg;
                emit_last  = read_done;
                if (out_free) begin
                    emit        = 1'b1;
                    head_next   = inc_idx(head_reg);
                    rd_addr     = inc_idx(head_reg);
                    fill_next   = fill_reg - 1'b1;
                    remain_next = remain_reg - 7'd1;
                    if (rd_data_reg == CH_LF) begin
                        nl_total_next = nl_total_reg - 1'b1;
                    end
                end
            end
            default: begin
                idx_next = 3'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            head_reg     <= '0;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            nl_total_reg <= '0;
            readable_reg <= 1'b0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            nl_total_reg <= nl_total_next;
            readable_reg <= readable_next;
            ovf_reg      <= ovf_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        last_lf_reg    <= last_lf_next;
        pat_reg        <= pat_next;
        idx_reg        <= idx_next;
        byte_reg       <= byte_next;
        remain_reg     <= remain_next;
        canon_reg      <= canon_next;
        erase_echo_reg <= erase_echo_next;
        erase_ctl_reg  <= erase_ctl_next;
        if (emit) begin
            m_kind_reg     <= emit_kind;
            m_value_reg    <= emit_value;
            m_last_reg     <= emit_last;
            m_readable_reg <= readable_reg;
            m_ovf_reg      <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_ptr_reg] <= cmd.c;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_value      = m_value_reg;
    assign m_last       = m_last_reg;
    assign m_readable   = m_readable_reg;
    assign m_overflowed = m_ovf_reg;

endmodule

/* src/tty_line_discipline_top.sv */
// ----------------------------------------------------------------------------
// tty_line_discipline_top
// Terminal input line discipline: translation, erase, echo, input FIFO and
// read requests.
// ----------------------------------------------------------------------------
// The front end takes one transaction per cycle while its two-entry command
// queue has room; a dropped CR costs the back end nothing. The back end runs
// one command at a time: a received byte echoes up to two characters, an
// erase of a non-empty buffer reads its last byte and echoes up to six
// characters, and a read sets up the FIFO read address and then returns the
// requested bytes through the single read port of the byte FIFO. A
// would-block or empty read gives a single status result. Results stall only
// on m_ready; the FIFO needs no clearing after reset.
module tty_line_discipline_top #(
    parameter int FIFO_DEPTH = 256,
    parameter int READ_MAX   = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tld_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [7:0]                      s_rx_byte,
    input  logic                            s_chunk_last,
    input  logic [6:0]                      s_read_count,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_kind,
    output logic [7:0]                      m_value,
    output logic                            m_last,
    output logic                            m_readable,
    output logic                            m_overflowed
);
    import tld_pkg::*;

    cfg_t cfg_reg;
    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic pop, pop_valid;
    cmd_t pop_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.input_flags <= 3'd2;
            cfg_reg.local_flags <= 5'd23;
            cfg_reg.erase_char  <= 8'd127;
            cfg_reg.eof_char    <= 8'd4;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_INPUT_FLAGS: cfg_reg.input_flags <= cfg_data[2:0];
                CFG_LOCAL_FLAGS: cfg_reg.local_flags <= cfg_data[4:0];
                CFG_ERASE_CHAR:  cfg_reg.erase_char  <= cfg_data;
                CFG_EOF_CHAR:    cfg_reg.eof_char    <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    tld_front #(
        .READ_MAX (READ_MAX)
    ) u_front (
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_rx_byte    (s_rx_byte),
        .s_read_count (s_read_count),
        .push_valid   (push_valid),
        .push_cmd     (push_cmd),
        .push_ready   (push_ready)
    );

    tld_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    tld_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (pop_valid),
        .cmd          (pop_cmd),
        .cmd_pop      (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_value      (m_value),
        .m_last       (m_last),
        .m_readable   (m_readable),
        .m_overflowed (m_overflowed)
    );

    // status-only results are single and carry no byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_BLOCK || m_kind == KIND_EMPTY) |-> m_last && m_value == 8'h00)
        else $error("status result not single or carries data");

    // would-block is only reported while input is not readable
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_BLOCK |-> !m_readable)
        else $error("would-block while readable");

    // overflow flag is sticky across results
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(m_valid && m_overflowed) && m_valid |-> m_overflowed)
        else $error("overflow flag cleared");

    // a waiting result holds its payload until accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_value)
        && $stable(m_last) && $stable(m_readable) && $stable(m_overflowed))
        else $error("result changed while waiting");

endmodule

/* bench/tld_line_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_line_scoreboard_pkg
// Expected-result tracking for the tty line discipline bench. The class keeps
// its own copy of the input buffer, the newline count, the readable and
// overflow flags and the four registers. For every accepted transaction it
// works out the echo and read results, and it checks each delivered result
// against the oldest one still awaited.
// ----------------------------------------------------------------------------
package tld_line_scoreboard_pkg;

    import tld_pkg::*;

    localparam int LINE_DEPTH = 256;
    localparam int READ_LIMIT = 64;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
        logic       readable;
        logic       overflowed;
    } line_result_t;

    class line_scoreboard;

        logic [7:0]   line_buf [LINE_DEPTH];
        int unsigned  head;
        int unsigned  fill;
        int unsigned  lf_count;
        bit           readable;
        bit           overflow;

        logic [2:0]   iflags;
        logic [4:0]   lflags;
        logic [7:0]   erase_ch;
        logic [7:0]   eof_ch;

        line_result_t step_out[$];
        line_result_t awaited_results[$];
        int           errors;

        function new();
            foreach (line_buf[i]) line_buf[i] = 8'h00;
            head     = 0;
            fill     = 0;
            lf_count = 0;
            readable = 1'b0;
            overflow = 1'b0;
            iflags   = 3'd2;
            lflags   = 5'd23;
            erase_ch = 8'h7F;
            eof_ch   = 8'h04;
            errors   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_INPUT_FLAGS: iflags = val[2:0];
                CFG_LOCAL_FLAGS: lflags = val[4:0];
                CFG_ERASE_CHAR:  erase_ch = val;
                CFG_EOF_CHAR:    eof_ch = val;
                default: ;
            endcase
        endfunction

        function bit ctrl_char(logic [7:0] b);
            return (b < 8'h20) || (b == 8'h7F);
        endfunction

        function void add(logic [1:0] kind, logic [7:0] value);
            line_result_t r;
            r = '0;
            r.kind = kind;
            r.value = value;
            step_out = {step_out, r};
        endfunction

        function void add_rubout();
            add(KIND_ECHO, CH_BS);
            add(KIND_ECHO, CH_SP);
            add(KIND_ECHO, CH_BS);
        endfunction

        function void take_byte(logic [7:0] c_in);
            logic [7:0]  c;
            logic [7:0]  d;
            bit          canon;
            bit          skip_store;
            int unsigned tail;
            c = c_in;
            canon = lflags[0];
            skip_store = 1'b0;
            if (c == CH_CR) begin
                if (iflags[0])
                    return;
                if (iflags[1])
                    c = CH_LF;
            end else if (c == CH_LF && iflags[2]) begin
                c = CH_CR;
            end
            if (canon) begin
                if (lflags[2] && c == erase_ch) begin
                    if (fill > 0) begin
                        tail = (head + fill - 1) % LINE_DEPTH;
                        d = line_buf[tail];
                        if (d != CH_LF) begin
                            fill--;
                            if (lflags[1]) begin
                                add_rubout();
                                if (lflags[4] && ctrl_char(d))
                                    add_rubout();
                            end
                        end
                    end
                    return;
                end else if (lflags[1] || (lflags[3] && c == CH_LF)) begin
                    if (c == eof_ch) begin
                        skip_store = 1'b1;
                    end else if (c != CH_LF && ctrl_char(c) && lflags[4]) begin
                        add(KIND_ECHO, CH_CARET);
                        add(KIND_ECHO, c + CTRL_OFFSET);
                    end else begin
                        add(KIND_ECHO, c);
                    end
                end
            end
            if (!skip_store) begin
                if (fill >= LINE_DEPTH) begin
                    overflow = 1'b1;
                end else begin
                    line_buf[(head + fill) % LINE_DEPTH] = c;
                    fill++;
                    if (c == CH_LF)
                        lf_count++;
                end
            end
            if (c == CH_LF || c == eof_ch || !canon)
                readable = 1'b1;
        endfunction

        function void serve_read(logic [6:0] cnt_in);
            int unsigned cnt;
            int unsigned take;
            logic [7:0]  b;
            bit          canon;
            canon = lflags[0];
            if (!readable) begin
                add(KIND_BLOCK, 8'h00);
                return;
            end
            cnt = (cnt_in > READ_LIMIT) ? READ_LIMIT : cnt_in;
            take = (cnt < fill) ? cnt : fill;
            for (int i = 0; i < take; i++) begin
                b = line_buf[head];
                head = (head + 1) % LINE_DEPTH;
                fill--;
                add(KIND_DATA, b);
                if (b == CH_LF) begin
                    lf_count--;
                    if (canon)
                        break;
                end
            end
            if (step_out.size() == 0)
                add(KIND_EMPTY, 8'h00);
            if (canon ? (lf_count == 0) : (fill == 0))
                readable = 1'b0;
        endfunction

        function void note_input(logic op, logic [7:0] b, logic [6:0] cnt);
            line_result_t r;
            step_out.delete();
            if (op == OP_READ)
                serve_read(cnt);
            else
                take_byte(b);
            foreach (step_out[i]) begin
                r = step_out[i];
                r.last = (i == step_out.size() - 1);
                r.readable = readable;
                r.overflowed = overflow;
                awaited_results = {awaited_results, r};
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] value, logic last,
                                   logic rd, logic ovf);
            line_result_t exp;
            if (awaited_results.size() == 0) begin
                $error("result transaction with nothing awaited: kind %0d value 0x%02h",
                       kind, value);
                errors++;
                return;
            end
            exp = awaited_results.pop_front();
            if (kind !== exp.kind) begin
                $error("kind: expected %0d, actual %0d", exp.kind, kind);
                errors++;
            end
            if (value !== exp.value) begin
                $error("value: expected 0x%02h, actual 0x%02h", exp.value, value);
                errors++;
            end
            if (last !== exp.last) begin
                $error("last: expected %0b, actual %0b", exp.last, last);
                errors++;
            end
            if (rd !== exp.readable) begin
                $error("readable: expected %0b, actual %0b", exp.readable, rd);
                errors++;
            end
            if (ovf !== exp.overflowed) begin
                $error("overflowed: expected %0b, actual %0b", exp.overflowed, ovf);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

    endclass

endpackage

/* bench/tty_line_discipline_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tty_line_discipline_top_tb
// Self-checking bench for the terminal line discipline. A directed pass walks
// through echo, caret echo, erase, end of file, newline translation and read
// corner cases; random passes then send short lines followed by reads, mixed
// with stray bytes and reads, under several register settings and idle
// patterns. A last pass fills the input buffer past its depth while the
// result side is held off, then drains it in raw mode.
// ----------------------------------------------------------------------------
module tty_line_discipline_top_tb;

    import tld_pkg::*;
    import tld_line_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 16;
    localparam int PHASE_ITEMS    = 5;

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_operation  = 1'b0;
    logic [7:0]            s_rx_byte    = '0;
    logic                  s_chunk_last = 1'b0;
    logic [6:0]            s_read_count = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [1:0]            m_kind;
    logic [7:0]            m_value;
    logic                  m_last;
    logic                  m_readable;
    logic                  m_overflowed;

    line_scoreboard sb;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    logic           rx_hold        = 1'b0;
    int             idle_cycles    = 0;
    event           hold_off_ev;

    tty_line_discipline_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_rx_byte    (s_rx_byte),
        .s_chunk_last (s_chunk_last),
        .s_read_count (s_read_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_value      (m_value),
        .m_last       (m_last),
        .m_readable   (m_readable),
        .m_overflowed (m_overflowed)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // result side: check accepted transactions, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_kind, m_value, m_last, m_readable, m_overflowed);
        m_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // long hold-off of the result side, counted here
    initial begin
        forever begin
            @(hold_off_ev);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_txn(input logic op, input logic [7:0] b, input logic [6:0] cnt);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_rx_byte    <= b;
        s_chunk_last <= 1'($urandom_range(1));
        s_read_count <= cnt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(op, b, cnt);
    endtask

    task automatic rx_char(input logic [7:0] b);
        send_txn(OP_RECEIVE, b, 7'($urandom_range(127)));
    endtask

    task automatic read_req(input logic [6:0] cnt);
        send_txn(OP_READ, 8'($urandom_range(255)), cnt);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_register(idx, val);
        @(posedge aclk);
    endtask

    task automatic apply_config(input logic [2:0] iflags, input logic [4:0] lflags,
                                input logic [7:0] erase_ch, input logic [7:0] eof_ch);
        write_reg(CFG_INPUT_FLAGS, {5'd0, iflags});
        write_reg(CFG_LOCAL_FLAGS, {3'd0, lflags});
        write_reg(CFG_ERASE_CHAR, erase_ch);
        write_reg(CFG_EOF_CHAR, eof_ch);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(99);
        if (sel < 12)
            return CH_LF;
        if (sel < 20)
            return CH_CR;
        if (sel < 28)
            return sb.erase_ch;
        if (sel < 34)
            return sb.eof_ch;
        if (sel < 46)
            return ($urandom_range(3) == 0) ? CH_DEL : 8'($urandom_range(31));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [6:0] pick_count();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return 7'd0;
        if (sel < 25)
            return 7'($urandom_range(127, 64));
        return 7'($urandom_range(16, 1));
    endfunction

    // mostly short lines followed by a read, with stray bytes and reads
    task automatic run_mixed(input int n_items);
        int done;
        int len;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(99) < 70) begin
                len = $urandom_range(6);
                repeat (len) rx_char(pick_byte());
                rx_char(($urandom_range(3) == 0) ? sb.eof_ch : CH_LF);
                read_req(pick_count());
                done += len + 2;
            end else begin
                if ($urandom_range(1))
                    read_req(pick_count());
                else
                    rx_char(pick_byte());
                done++;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: canonical, echo, erase, control echo, cr to lf
        read_req(7'd5);
        rx_char(8'h61);
        rx_char(8'h01);
        rx_char(CH_DEL);
        rx_char(CH_DEL);
        rx_char(CH_DEL);
        rx_char(8'hFF);
        rx_char(8'h80);
        rx_char(CH_CR);
        rx_char(CH_DEL);
        rx_char(8'h04);
        read_req(7'd0);
        read_req(7'd127);
        read_req(7'd3);
        rx_char(8'h00);
        rx_char(CH_LF);
        read_req(7'd64);
        rx_char(8'h04);
        read_req(7'd5);
        wait_drained();

        // raw mode, cr ignored, lf to cr
        apply_config(3'd7, 5'd0, 8'h00, 8'h00);
        rx_char(CH_CR);
        rx_char(CH_LF);
        rx_char(CH_DEL);
        read_req(7'd1);
        read_req(7'd127);
        read_req(7'd1);
        wait_drained();

        // erase without echo, echo of newline only, high erase and eof bytes
        apply_config(3'd0, 5'd13, 8'hFF, 8'h80);
        rx_char(8'h78);
        rx_char(8'hFF);
        rx_char(8'h80);
        rx_char(CH_LF);
        read_req(7'd64);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        apply_config(3'd0, 5'd31, CH_BS, 8'h04);
        run_mixed(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 80;
        recv_stall_pct = 0;
        apply_config(3'd7, 5'd0, 8'h00, 8'h00);
        run_mixed(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 80;
        apply_config(3'd1, 5'd23, 8'hFF, 8'hFF);
        run_mixed(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 21;
        recv_stall_pct = 21;
        apply_config(3'd4, 5'd27, 8'($urandom_range(255)), 8'($urandom_range(255)));
        run_mixed(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = $urandom_range(1) ? 21 : 0;
        recv_stall_pct = $urandom_range(1) ? 21 : 80;
        apply_config(3'($urandom_range(7)), 5'($urandom_range(31)),
                     8'($urandom_range(255)), 8'($urandom_range(255)));
        run_mixed(PHASE_ITEMS);
        wait_drained();

        // overfill the buffer with echo on while the result side holds off
        send_idle_pct = 0;
        recv_stall_pct = 0;
        apply_config(3'd0, 5'd3, 8'h00, 8'h00);
        -> hold_off_ev;
        repeat (LINE_DEPTH + 2) rx_char(8'($urandom_range(254, 32)));
        rx_char(CH_LF);
        read_req(7'd64);
        wait_drained();

        // drain what is left in raw mode
        recv_stall_pct = 21;
        apply_config(3'd2, 5'd0, 8'h7F, 8'h04);
        rx_char(8'h41);
        while (sb.fill > 0)
            read_req(7'd64);
        read_req(7'd64);
        wait_drained();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* tty_line_discipline_top.f */
src/tld_pkg.sv
src/tld_front.sv
src/tld_cmd_queue.sv
src/tld_back.sv
src/tty_line_discipline_top.sv
bench/tld_line_scoreboard_pkg.sv
bench/tty_line_discipline_top_tb.sv
